FILE: hdl/vertex_quantize_and_dedup_macros.svh
// Assertion helpers for the vertex quantizer.
`ifndef VERTEX_QUANTIZE_AND_DEDUP_MACROS_SVH
`define VERTEX_QUANTIZE_AND_DEDUP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define VQD_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define VQD_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/vqd_pkg.sv
`default_nettype none
package vqd_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned KEY_W = 63;
  localparam int unsigned VID_W = 12;
  localparam int unsigned AXIS_MAX_W = 21;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [31:0] HASH_LO = 32'h7F4A_7C15;
  localparam logic [31:0] HASH_HI = 32'h9E37_79B9;
  localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_RECIP_X  = 3'd3,
    REG_RECIP_Y  = 3'd4,
    REG_RECIP_Z  = 3'd5,
    REG_DEDUP    = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_MOD,
    S_PROBE,
    S_CHECK,
    S_DONE
  } state_t;

  // Clamp a Q32.32 product to [0, mask] and round half up.
  function automatic logic [AXIS_MAX_W-1:0] quant(input logic [63:0] p, input logic pos,
                                                  input logic [AXIS_MAX_W-1:0] mask);
    logic [63:0] lim;
    logic [63:0] r;
    lim = {11'd0, mask, 32'd0};
    r = p + ROUND_HALF;
    if (!pos) begin
      quant = '0;
    end else if (p >= lim) begin
      quant = mask;
    end else begin
      quant = r[32 +: AXIS_MAX_W];
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/vqd_if.sv
`default_nettype none
interface vqd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] coord_x;
  logic [31:0] coord_y;
  logic [31:0] coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface vqd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] vertex_id;
  logic [62:0] packed_key;
  logic        is_new;
  logic        overflow;
  modport source (output valid, vertex_id, packed_key, is_new, overflow, input ready);
  modport sink (input valid, vertex_id, packed_key, is_new, overflow, output ready);
endinterface
`default_nettype wire

FILE: hdl/vertex_quantize_and_dedup.sv
// Takes one vertex at a time: a request is accepted only in the idle state, which is
// reached after the result of the previous vertex has been loaded into the result
// register; that load waits while the result before it has not been taken. The single
// 32x32 multiplier is shared by the axis products, the hash and, when TABLE_SLOTS is not
// a power of two, the remainder. Synchronous active-high reset clears control state and
// runs a clearing pass over the slot memory.
`default_nettype none
module vertex_quantize_and_dedup
  import vqd_pkg::*;
#(
  parameter int unsigned AXIS_BITS_X = 21,
  parameter int unsigned AXIS_BITS_Y = 21,
  parameter int unsigned AXIS_BITS_Z = 21,
  parameter int unsigned VERTEX_CAPACITY = 4096,
  parameter int unsigned TABLE_SLOTS = 8192
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 write_enable,
  input  wire logic [CFG_IDX_W-1:0] write_index,
  input  wire logic [31:0]          write_data,
  vqd_in_if.sink                    vertex,
  vqd_out_if.source                 result
);

  localparam int unsigned SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned PW = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned IW = $clog2(VERTEX_CAPACITY);
  localparam int unsigned CW = $clog2(VERTEX_CAPACITY + 1);
  localparam int unsigned MW = 1 + IW + KEY_W;
  localparam bit SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
  localparam logic [AXIS_MAX_W-1:0] MASK_X = AXIS_MAX_W'((64'd1 << AXIS_BITS_X) - 64'd1);
  localparam logic [AXIS_MAX_W-1:0] MASK_Y = AXIS_MAX_W'((64'd1 << AXIS_BITS_Y) - 64'd1);
  localparam logic [AXIS_MAX_W-1:0] MASK_Z = AXIS_MAX_W'((64'd1 << AXIS_BITS_Z) - 64'd1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SLOTS - 1);
  localparam logic [31:0] SLOTS_32 = 32'(TABLE_SLOTS);
  // floor(2^32 / TABLE_SLOTS): quotient estimate is exact or one short.
  localparam logic [31:0] SLOTS_RECIP = 32'((64'd1 << 32) / TABLE_SLOTS);

  // Configuration registers.
  logic [31:0] origin_x, origin_y, origin_z;
  logic [31:0] recip_x, recip_y, recip_z;
  logic        dedup_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_y <= '0;
      origin_z <= '0;
      recip_x <= 32'd65536;
      recip_y <= 32'd65536;
      recip_z <= 32'd65536;
      dedup_enable <= 1'b1;
    end else if (write_enable) begin
      case (write_index)
        REG_ORIGIN_X: origin_x <= write_data;
        REG_ORIGIN_Y: origin_y <= write_data;
        REG_ORIGIN_Z: origin_z <= write_data;
        REG_RECIP_X:  recip_x <= write_data;
        REG_RECIP_Y:  recip_y <= write_data;
        REG_RECIP_Z:  recip_z <= write_data;
        REG_DEDUP:    dedup_enable <= write_data[0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [2:0]    step;
  logic [SW-1:0] slot;
  logic [SW-1:0] clr_addr;
  logic [PW-1:0] probes;
  logic [CW-1:0] next_id;

  // Per-axis offsets from the origin; their magnitude and sign are captured with the request.
  logic [32:0] diff_x, diff_y, diff_z;
  logic [31:0] mag [3];
  logic        pos [3];
  logic [AXIS_BITS_X-1:0] qx;
  logic [AXIS_BITS_Y-1:0] qy;
  logic [AXIS_BITS_Z-1:0] qz;
  logic [KEY_W-1:0] key;
  logic [31:0] hacc;

  // Shared multiplier: one product per cycle, registered.
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [CW-1:0] res_id;
  logic          res_new, res_ovf;
  logic          out_valid;

  logic [MW-1:0] slot_mem [TABLE_SLOTS];
  logic [MW-1:0] rd_word;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  logic          rd_valid;
  logic [IW-1:0] rd_id;
  logic [KEY_W-1:0] rd_key;
  logic          ids_left;
  logic          take;
  logic [31:0]   mod_r;
  logic [SW-1:0] slot_inc;

  assign diff_x = {vertex.coord_x[31], vertex.coord_x} - {origin_x[31], origin_x};
  assign diff_y = {vertex.coord_y[31], vertex.coord_y} - {origin_y[31], origin_y};
  assign diff_z = {vertex.coord_z[31], vertex.coord_z} - {origin_z[31], origin_z};

  assign key = (KEY_W'(qz) << (AXIS_BITS_X + AXIS_BITS_Y)) | (KEY_W'(qy) << AXIS_BITS_X)
             | KEY_W'(qx);
  assign ids_left = next_id < CW'(VERTEX_CAPACITY);
  assign take = vertex.valid && vertex.ready;
  assign {rd_valid, rd_id, rd_key} = rd_word;
  // Hash minus quotient estimate times slot count: below twice the slot count.
  assign mod_r = hacc - prod[31:0];
  assign slot_inc = (slot == LAST_SLOT) ? '0 : slot + 1'b1;

  // Multiplier operand select: axes first, then the three hash partial products;
  // the remainder reuses it for the quotient estimate and its back-multiply.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_MOD) begin
      case (step)
        3'd0: begin mul_a = hacc; mul_b = SLOTS_RECIP; end
        3'd1: begin mul_a = prod[63:32]; mul_b = SLOTS_32; end
        default: ;
      endcase
    end else begin
      case (step)
        3'd0: begin mul_a = mag[0]; mul_b = recip_x; end
        3'd1: begin mul_a = mag[1]; mul_b = recip_y; end
        3'd2: begin mul_a = mag[2]; mul_b = recip_z; end
        3'd4: begin mul_a = key[31:0]; mul_b = HASH_LO; end
        3'd5: begin mul_a = key[31:0]; mul_b = HASH_HI; end
        3'd6: begin mul_a = {1'b0, key[62:32]}; mul_b = HASH_LO; end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == LAST_SLOT) state_next = S_IDLE;
      S_IDLE:  if (take) state_next = S_MUL;
      S_MUL: begin
        if (step == 3'd3 && !dedup_enable) begin
          state_next = S_DONE;
        end else if (step == 3'd7) begin
          state_next = SLOTS_POW2 ? S_PROBE : S_MOD;
        end
      end
      S_MOD:   if (step == 3'd2) state_next = S_PROBE;
      S_PROBE: state_next = S_CHECK;
      S_CHECK: begin
        if (!rd_valid || rd_key == key || probes == PW'(TABLE_SLOTS - 1)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_PROBE;
        end
      end
      S_DONE:  if (!out_valid) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Outputs of the sequencer: request ready and memory write port.
  always_comb begin
    vertex.ready = 1'b0;
    mem_we = 1'b0;
    mem_waddr = slot;
    mem_wdata = {1'b1, IW'(next_id), key};
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_IDLE:  vertex.ready = 1'b1;
      S_CHECK: mem_we = !rd_valid && ids_left;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) slot_mem[mem_waddr] <= mem_wdata;
    rd_word <= slot_mem[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      next_id <= '0;
      out_valid <= 1'b0;
      step <= '0;
    end else begin
      state <= state_next;
      if (out_valid && result.ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + 1'b1;
        S_IDLE: begin
          step <= '0;
          // Hold magnitude and sign of each offset; a non-positive offset quantizes to 0.
          mag[0] <= diff_x[31:0];
          mag[1] <= diff_y[31:0];
          mag[2] <= diff_z[31:0];
          pos[0] <= !diff_x[32] && (diff_x != '0);
          pos[1] <= !diff_y[32] && (diff_y != '0);
          pos[2] <= !diff_z[32] && (diff_z != '0);
        end
        S_MUL: begin
          step <= step + 1'b1;
          case (step)
            3'd1: qx <= AXIS_BITS_X'(quant(prod, pos[0], MASK_X));
            3'd2: qy <= AXIS_BITS_Y'(quant(prod, pos[1], MASK_Y));
            3'd3: begin
              qz <= AXIS_BITS_Z'(quant(prod, pos[2], MASK_Z));
              if (!dedup_enable) begin
                res_id <= ids_left ? next_id : '0;
                res_new <= ids_left;
                res_ovf <= !ids_left;
                if (ids_left) next_id <= next_id + 1'b1;
              end
            end
            3'd5: hacc <= prod[63:32];
            3'd6: hacc <= hacc + prod[31:0];
            3'd7: begin
              hacc <= hacc + prod[31:0];
              slot <= SW'(hacc + prod[31:0]);
            end
            default: ;
          endcase
          probes <= '0;
        end
        S_MOD: begin
          // Estimate, back-multiply, then one conditional subtract.
          step <= step + 1'b1;
          if (step == 3'd2) begin
            slot <= (mod_r >= SLOTS_32) ? SW'(mod_r - SLOTS_32) : SW'(mod_r);
          end
        end
        S_CHECK: begin
          res_new <= 1'b0;
          res_ovf <= 1'b0;
          res_id <= '0;
          if (!rd_valid) begin
            if (ids_left) begin
              res_id <= next_id;
              res_new <= 1'b1;
              next_id <= next_id + 1'b1;
            end else begin
              res_ovf <= 1'b1;
            end
          end else if (rd_key == key) begin
            res_id <= CW'(rd_id);
          end else begin
            slot <= slot_inc;
            probes <= probes + 1'b1;
            if (probes == PW'(TABLE_SLOTS - 1)) res_ovf <= 1'b1;
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            result.vertex_id <= VID_W'(res_id);
            result.packed_key <= key;
            result.is_new <= res_new;
            result.overflow <= res_ovf;
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid = out_valid;

`include "vertex_quantize_and_dedup_macros.svh"

  `VQD_CHECK(no_req_in_clear, (state == S_CLEAR) |-> !vertex.ready, "request taken while clearing")
  `VQD_CHECK(id_in_range, next_id <= CW'(VERTEX_CAPACITY), "id counter past capacity")
  `VQD_CHECK(new_xor_ovf, result.valid |-> !(result.is_new && result.overflow), "new and overflow")
  `VQD_CHECK(id_step, (next_id != $past(next_id)) |-> ($past(state) == S_CHECK || $past(state) == S_MUL), "id moved outside insert")

endmodule
`default_nettype wire
